@@ rtl/hsrs_pkg.sv @@
// Shared types, codes and constants of the humidity sensor readout sequencer.
package hsrs_pkg;

    // Field widths of the input and result beats.
    localparam int ACTION_W   = 2;
    localparam int RDATA_W    = 48;
    localparam int KIND_W     = 2;
    localparam int ADDR_W     = 7;
    localparam int TX_W       = 24;
    localparam int COUNT_W    = 3;
    localparam int TEMP_W     = 12;
    localparam int HUM_W      = 7;
    localparam int WAIT_W     = 8;

    // Configuration port.
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;

    localparam logic [CFG_IDX_W-1:0] CFG_DEVICE_ADDRESS     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RESET_WAIT_MS      = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_INIT_WAIT_MS       = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CONVERSION_WAIT_MS = 2'd3;

    localparam logic [ADDR_W-1:0] DEVICE_ADDRESS_RST     = 7'h38;
    localparam logic [WAIT_W-1:0] RESET_WAIT_MS_RST      = 8'd20;
    localparam logic [WAIT_W-1:0] INIT_WAIT_MS_RST       = 8'd10;
    localparam logic [WAIT_W-1:0] CONVERSION_WAIT_MS_RST = 8'd80;

    // Input action codes.
    localparam logic [ACTION_W-1:0] ACT_START = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_TICK  = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_DONE  = 2'd2;

    // Result kind codes.
    localparam logic [KIND_W-1:0] KIND_REQUEST = 2'd0;
    localparam logic [KIND_W-1:0] KIND_VALID   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_FAILED  = 2'd2;

    // Sensor command words, first byte in the top byte.
    localparam logic [TX_W-1:0] CMD_INIT    = 24'hBE0800;
    localparam logic [TX_W-1:0] CMD_SRESET  = 24'hBA0000;
    localparam logic [TX_W-1:0] CMD_TRIGGER = 24'hAC3300;

    localparam logic [COUNT_W-1:0] CNT_CMD    = 3'd3;
    localparam logic [COUNT_W-1:0] CNT_SRESET = 3'd1;
    localparam logic [COUNT_W-1:0] CNT_STATUS = 3'd1;
    localparam logic [COUNT_W-1:0] CNT_DATA   = 3'd6;

    // Status byte flags.
    localparam int STATUS_CAL_BIT  = 3;
    localparam int STATUS_BUSY_BIT = 7;

    // Conversion constants.
    localparam logic [10:0] TEMP_SCALE  = 11'd2000;
    localparam logic [6:0]  HUM_SCALE   = 7'd100;
    localparam logic [TEMP_W-1:0] TEMP_OFFSET = 12'd500;
    localparam logic [HUM_W-1:0]  HUM_MAX     = 7'd100;

    // One result beat.
    typedef struct packed {
        logic [KIND_W-1:0]         kind;
        logic                      bus_read;
        logic [ADDR_W-1:0]         bus_address;
        logic [TX_W-1:0]           tx_bytes;
        logic [COUNT_W-1:0]        byte_count;
        logic signed [TEMP_W-1:0]  temperature_x10;
        logic [HUM_W-1:0]          humidity_pct;
    } t_result;

endpackage

@@ rtl/hsrs_in_if.sv @@
// Input channel of the sequencer: events from the tick source and the I2C master.
interface hsrs_in_if;
    import hsrs_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [ACTION_W-1:0]  action;
    logic                 transfer_ok;
    logic [RDATA_W-1:0]   read_data;

    modport source (output valid, output action, output transfer_ok, output read_data,
                    input ready);
    modport sink   (input valid, input action, input transfer_ok, input read_data,
                    output ready);
endinterface

@@ rtl/hsrs_out_if.sv @@
// Result channel of the sequencer: bus requests and measurement results.
interface hsrs_out_if;
    import hsrs_pkg::*;

    logic                       valid;
    logic                       ready;
    logic [KIND_W-1:0]          kind;
    logic                       bus_read;
    logic [ADDR_W-1:0]          bus_address;
    logic [TX_W-1:0]            tx_bytes;
    logic [COUNT_W-1:0]         byte_count;
    logic signed [TEMP_W-1:0]   temperature_x10;
    logic [HUM_W-1:0]           humidity_pct;

    modport source (output valid, output kind, output bus_read, output bus_address,
                    output tx_bytes, output byte_count, output temperature_x10,
                    output humidity_pct, input ready);
    modport sink   (input valid, input kind, input bus_read, input bus_address,
                    input tx_bytes, input byte_count, input temperature_x10,
                    input humidity_pct, output ready);
endinterface

@@ rtl/hsrs_convert.sv @@
// Converts the six-byte sensor frame into rounded temperature and humidity.
module hsrs_convert (
    input  logic [hsrs_pkg::RDATA_W-1:0]       i_read_data,
    output logic signed [hsrs_pkg::TEMP_W-1:0] o_temperature_x10,
    output logic [hsrs_pkg::HUM_W-1:0]         o_humidity_pct
);
    import hsrs_pkg::*;

    logic [19:0] raw_hum;
    logic [19:0] raw_temp;
    logic [30:0] temp_prod;
    logic [26:0] hum_prod;
    logic [10:0] temp_q;
    logic [6:0]  hum_q;

    // Humidity raw is bytes 1, 2 and the high nibble of byte 3; temperature the rest.
    assign raw_hum  = i_read_data[39:20];
    assign raw_temp = i_read_data[19:0];

    // Scale and round to nearest: add half an LSB of the 2^20 divisor.
    assign temp_prod = 31'(raw_temp) * 31'(TEMP_SCALE) + 31'(1 << 19);
    assign hum_prod  = 27'(raw_hum) * 27'(HUM_SCALE) + 27'(1 << 19);
    assign temp_q    = temp_prod[30:20];
    assign hum_q     = hum_prod[26:20];

    // Temperature offset of fifty degrees, humidity clamped at full scale.
    assign o_temperature_x10 = signed'({1'b0, temp_q} - TEMP_OFFSET);
    assign o_humidity_pct    = (hum_q > HUM_MAX) ? HUM_MAX : hum_q;

endmodule

@@ rtl/humidity_sensor_readout_sequencer.sv @@
// Top level of the humidity sensor readout sequencer.
//
// The block drives one measurement of an I2C humidity and temperature sensor
// through an external I2C master. Beats on i_in carry a start request, a
// millisecond tick or a transfer completion with its status and read bytes.
// Beats on o_out carry either a bus transfer request for the master or the
// final result: a valid measurement or a failure.
//
// Each input beat is decoded by the phase sequencer in the cycle it is
// accepted; any result it causes is registered in the output register, or
// in the skid while the receiver stalls. One input beat is accepted every
// cycle while i_in.ready is high. The output register plus a one-beat skid
// register decouple the sides: i_in.ready drops only while the skid holds a
// beat, that is when the receiver has stalled with two results pending.
//
// Configuration writes on i_cfg_* take effect at once; the user must make
// them only while no measurement is in progress; the block does not enforce
// it. A synchronous reset returns the sequencer to idle, empties both output
// registers, restores default address and wait times, keeps i_in.ready low.
module humidity_sensor_readout_sequencer (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [hsrs_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [hsrs_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    hsrs_in_if.sink                           i_in,
    hsrs_out_if.source                        o_out
);
    import hsrs_pkg::*;

    typedef enum logic [9:0] {
        PH_IDLE    = 10'b00_0000_0001,
        PH_INIT1   = 10'b00_0000_0010,
        PH_RESET   = 10'b00_0000_0100,
        PH_RWAIT   = 10'b00_0000_1000,
        PH_INIT2   = 10'b00_0001_0000,
        PH_IWAIT   = 10'b00_0010_0000,
        PH_STATUS  = 10'b00_0100_0000,
        PH_TRIGGER = 10'b00_1000_0000,
        PH_CWAIT   = 10'b01_0000_0000,
        PH_DATA    = 10'b10_0000_0000
    } t_phase;

    t_phase              r_phase, n_phase;
    logic [WAIT_W-1:0]   r_wait, n_wait;
    logic [ADDR_W-1:0]   r_dev_addr;
    logic [WAIT_W-1:0]   r_reset_wait;
    logic [WAIT_W-1:0]   r_init_wait;
    logic [WAIT_W-1:0]   r_conv_wait;
    logic                r_run;
    logic                r_out_valid;
    logic                r_skd_valid;
    t_result             r_out;
    t_result             r_skd;

    logic                in_accept;
    logic                out_take;
    logic                ok;
    logic [WAIT_W-1:0]   wait_dec;
    logic                res_valid;
    t_result             res;
    logic signed [TEMP_W-1:0] conv_temp;
    logic [HUM_W-1:0]         conv_hum;

    // Builds a bus request beat.
    function automatic t_result f_request(input logic rd, input logic [TX_W-1:0] tx,
                                          input logic [COUNT_W-1:0] cnt,
                                          input logic [ADDR_W-1:0] addr);
        t_result r;
        r             = '0;
        r.kind        = KIND_REQUEST;
        r.bus_read    = rd;
        r.bus_address = addr;
        r.tx_bytes    = tx;
        r.byte_count  = cnt;
        return r;
    endfunction

    // Builds a failure beat.
    function automatic t_result f_failed();
        t_result r;
        r      = '0;
        r.kind = KIND_FAILED;
        return r;
    endfunction

    // A zero wait setting counts as one tick.
    function automatic logic [WAIT_W-1:0] f_wait(input logic [WAIT_W-1:0] ticks);
        return (ticks == '0) ? WAIT_W'(1) : ticks;
    endfunction

    hsrs_convert u_convert (
        .i_read_data       (i_in.read_data),
        .o_temperature_x10 (conv_temp),
        .o_humidity_pct    (conv_hum)
    );

    assign in_accept = i_in.valid && i_in.ready;
    assign out_take  = r_out_valid && o_out.ready;
    assign ok        = i_in.transfer_ok;
    assign wait_dec  = r_wait - WAIT_W'(1);
    assign i_in.ready = r_run && !r_skd_valid;

    // Phase sequencer: one accepted input beat per cycle, at most one result.
    always_comb begin
        n_phase   = r_phase;
        n_wait    = r_wait;
        res_valid = 1'b0;
        res       = '0;
        if (in_accept) begin
            case (r_phase)
                PH_IDLE: begin
                    if (i_in.action == ACT_START) begin
                        n_phase   = PH_INIT1;
                        res_valid = 1'b1;
                        res       = f_request(1'b0, CMD_INIT, CNT_CMD, r_dev_addr);
                    end
                end
                PH_INIT1: begin
                    if (i_in.action == ACT_DONE) begin
                        if (ok) begin
                            n_phase = PH_IWAIT;
                            n_wait  = f_wait(r_init_wait);
                        end else begin
                            n_phase   = PH_RESET;
                            res_valid = 1'b1;
                            res       = f_request(1'b0, CMD_SRESET, CNT_SRESET, r_dev_addr);
                        end
                    end
                end
                PH_RESET: begin
                    // The soft reset status is not checked.
                    if (i_in.action == ACT_DONE) begin
                        n_phase = PH_RWAIT;
                        n_wait  = f_wait(r_reset_wait);
                    end
                end
                PH_RWAIT, PH_IWAIT, PH_CWAIT: begin
                    if (i_in.action == ACT_TICK) begin
                        n_wait = wait_dec;
                        if (wait_dec == '0) begin
                            res_valid = 1'b1;
                            if (r_phase == PH_RWAIT) begin
                                n_phase = PH_INIT2;
                                res     = f_request(1'b0, CMD_INIT, CNT_CMD, r_dev_addr);
                            end else if (r_phase == PH_IWAIT) begin
                                n_phase = PH_STATUS;
                                res     = f_request(1'b1, '0, CNT_STATUS, r_dev_addr);
                            end else begin
                                n_phase = PH_DATA;
                                res     = f_request(1'b1, '0, CNT_DATA, r_dev_addr);
                            end
                        end
                    end
                end
                PH_INIT2: begin
                    if (i_in.action == ACT_DONE) begin
                        if (!ok) begin
                            n_phase   = PH_IDLE;
                            res_valid = 1'b1;
                            res       = f_failed();
                        end else begin
                            n_phase = PH_IWAIT;
                            n_wait  = f_wait(r_init_wait);
                        end
                    end
                end
                PH_STATUS: begin
                    if (i_in.action == ACT_DONE) begin
                        res_valid = 1'b1;
                        if (!ok || !i_in.read_data[STATUS_CAL_BIT]) begin
                            n_phase = PH_IDLE;
                            res     = f_failed();
                        end else begin
                            n_phase = PH_TRIGGER;
                            res     = f_request(1'b0, CMD_TRIGGER, CNT_CMD, r_dev_addr);
                        end
                    end
                end
                PH_TRIGGER: begin
                    if (i_in.action == ACT_DONE) begin
                        if (!ok) begin
                            n_phase   = PH_IDLE;
                            res_valid = 1'b1;
                            res       = f_failed();
                        end else begin
                            n_phase = PH_CWAIT;
                            n_wait  = f_wait(r_conv_wait);
                        end
                    end
                end
                PH_DATA: begin
                    if (i_in.action == ACT_DONE) begin
                        res_valid = 1'b1;
                        n_phase   = PH_IDLE;
                        if (!ok || i_in.read_data[40 + STATUS_BUSY_BIT]) begin
                            res = f_failed();
                        end else begin
                            res.kind            = KIND_VALID;
                            res.temperature_x10 = conv_temp;
                            res.humidity_pct    = conv_hum;
                        end
                    end
                end
                default: begin
                    n_phase = PH_IDLE;
                end
            endcase
        end
    end

    // Sequencer state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_wait  <= '0;
            r_run   <= 1'b0;
        end else begin
            r_phase <= n_phase;
            r_wait  <= n_wait;
            r_run   <= 1'b1;
        end
    end

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dev_addr   <= DEVICE_ADDRESS_RST;
            r_reset_wait <= RESET_WAIT_MS_RST;
            r_init_wait  <= INIT_WAIT_MS_RST;
            r_conv_wait  <= CONVERSION_WAIT_MS_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_DEVICE_ADDRESS:     r_dev_addr   <= i_cfg_data[ADDR_W-1:0];
                CFG_RESET_WAIT_MS:      r_reset_wait <= i_cfg_data[WAIT_W-1:0];
                CFG_INIT_WAIT_MS:       r_init_wait  <= i_cfg_data[WAIT_W-1:0];
                CFG_CONVERSION_WAIT_MS: r_conv_wait  <= i_cfg_data[WAIT_W-1:0];
                default: ;
            endcase
        end
    end

    // Output register with a one-beat skid behind it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_skd_valid <= 1'b0;
        end else if (out_take || !r_out_valid) begin
            if (r_skd_valid) begin
                r_out       <= r_skd;
                r_out_valid <= 1'b1;
                r_skd_valid <= 1'b0;
            end else begin
                r_out       <= res;
                r_out_valid <= res_valid;
            end
        end else if (res_valid) begin
            r_skd       <= res;
            r_skd_valid <= 1'b1;
        end
    end

    assign o_out.valid           = r_out_valid;
    assign o_out.kind            = r_out.kind;
    assign o_out.bus_read        = r_out.bus_read;
    assign o_out.bus_address     = r_out.bus_address;
    assign o_out.tx_bytes        = r_out.tx_bytes;
    assign o_out.byte_count      = r_out.byte_count;
    assign o_out.temperature_x10 = r_out.temperature_x10;
    assign o_out.humidity_pct    = r_out.humidity_pct;

    // The skid only ever holds a beat behind an occupied output register.
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skd_valid |-> r_out_valid)
        else $error("skid register holds a beat while the output register is empty");

    // The skid fills only when the receiver stalled a pending beat.
    a_skid_fill_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!r_skd_valid ##1 r_skd_valid) |-> $past(r_out_valid && !o_out.ready))
        else $error("skid register filled without a stalled output");

    // A wait phase always has ticks left to count.
    a_wait_count_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_RWAIT || r_phase == PH_IWAIT || r_phase == PH_CWAIT)
            |-> (r_wait != '0))
        else $error("wait phase entered with an empty tick counter");

endmodule

@@ tb/testbench.sv @@
// Self-checking testbench of the humidity sensor readout sequencer with a built-in predictor.
module testbench;
    import hsrs_pkg::*;

    localparam logic [ACTION_W-1:0] ACT_NONE = 2'd3;
    localparam int QUIET_LIMIT = 2000;
    localparam int MAX_REPORTS = 10;
    localparam int NUM_EPOCHS  = 9;

    // Sequencer phases as the predictor tracks them.
    typedef enum logic [3:0] {
        S_IDLE, S_INIT, S_SRESET, S_RESET_WAIT, S_REINIT,
        S_INIT_WAIT, S_STATUS, S_TRIGGER, S_CONV_WAIT, S_DATA
    } seq_state_e;

    // One row of the directed stimulus table.
    typedef struct {
        logic [ACTION_W-1:0] act;
        logic                ok;
        logic [RDATA_W-1:0]  rdata;
        bit                  typed;
        bit                  has;
        t_result             res;
    } dir_row_t;

    // Results that can be read straight off the sensor protocol, at the reset address.
    localparam t_result X_NONE = '0;
    localparam t_result X_INIT = '{kind: KIND_REQUEST, bus_read: 1'b0,
        bus_address: DEVICE_ADDRESS_RST, tx_bytes: CMD_INIT, byte_count: CNT_CMD,
        temperature_x10: 12'sd0, humidity_pct: 7'd0};
    localparam t_result X_SRESET = '{kind: KIND_REQUEST, bus_read: 1'b0,
        bus_address: DEVICE_ADDRESS_RST, tx_bytes: CMD_SRESET, byte_count: CNT_SRESET,
        temperature_x10: 12'sd0, humidity_pct: 7'd0};
    localparam t_result X_STATUS = '{kind: KIND_REQUEST, bus_read: 1'b1,
        bus_address: DEVICE_ADDRESS_RST, tx_bytes: 24'd0, byte_count: CNT_STATUS,
        temperature_x10: 12'sd0, humidity_pct: 7'd0};
    localparam t_result X_TRIGGER = '{kind: KIND_REQUEST, bus_read: 1'b0,
        bus_address: DEVICE_ADDRESS_RST, tx_bytes: CMD_TRIGGER, byte_count: CNT_CMD,
        temperature_x10: 12'sd0, humidity_pct: 7'd0};
    localparam t_result X_DATA = '{kind: KIND_REQUEST, bus_read: 1'b1,
        bus_address: DEVICE_ADDRESS_RST, tx_bytes: 24'd0, byte_count: CNT_DATA,
        temperature_x10: 12'sd0, humidity_pct: 7'd0};
    localparam t_result X_FAIL = '{kind: KIND_FAILED, bus_read: 1'b0,
        bus_address: 7'd0, tx_bytes: 24'd0, byte_count: 3'd0,
        temperature_x10: 12'sd0, humidity_pct: 7'd0};
    localparam t_result X_HOT = '{kind: KIND_VALID, bus_read: 1'b0,
        bus_address: 7'd0, tx_bytes: 24'd0, byte_count: 3'd0,
        temperature_x10: 12'sd1500, humidity_pct: 7'd100};

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    hsrs_in_if  in_bus();
    hsrs_out_if out_bus();

    humidity_sensor_readout_sequencer dut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg_we  (i_cfg_we),
        .i_cfg_idx (i_cfg_idx),
        .i_cfg_data(i_cfg_data),
        .i_in      (in_bus),
        .o_out     (out_bus)
    );

    // Predictor state and its copy of the configuration.
    seq_state_e        seq_state;
    logic [WAIT_W-1:0] ticks_left;
    logic [ADDR_W-1:0] cfg_addr;
    logic [WAIT_W-1:0] cfg_reset_wait;
    logic [WAIT_W-1:0] cfg_init_wait;
    logic [WAIT_W-1:0] cfg_conv_wait;

    t_result  pending_results[$];
    dir_row_t dir_rows[25];
    int       mismatch_count;
    int       quiet_cycles;
    int       burst_left;
    t_result  seen;
    t_result  want;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Bus request aimed at the configured sensor address.
    function automatic t_result request(input logic rd, input logic [TX_W-1:0] tx,
                                        input logic [COUNT_W-1:0] cnt);
        t_result r;
        r = '0;
        r.kind = KIND_REQUEST;
        r.bus_read = rd;
        r.bus_address = cfg_addr;
        r.tx_bytes = tx;
        r.byte_count = cnt;
        return r;
    endfunction

    function automatic t_result failure();
        t_result r;
        r = '0;
        r.kind = KIND_FAILED;
        seq_state = S_IDLE;
        return r;
    endfunction

    // A zero wait still takes one tick.
    function automatic void arm_wait(input seq_state_e next, input logic [WAIT_W-1:0] ticks);
        ticks_left = (ticks == '0) ? 8'd1 : ticks;
        seq_state = next;
    endfunction

    // Advances the predicted sequencer by one event; returns 1 when it yields a result.
    function automatic bit sequence_step(input logic [ACTION_W-1:0] act, input logic ok,
                                         input logic [RDATA_W-1:0] rdata,
                                         output t_result res);
        logic [31:0] t_raw;
        logic [31:0] h_raw;
        logic [31:0] t_scaled;
        logic [31:0] h_scaled;
        res = '0;
        if (act == ACT_START) begin
            if (seq_state != S_IDLE) return 1'b0;
            seq_state = S_INIT;
            res = request(1'b0, CMD_INIT, CNT_CMD);
            return 1'b1;
        end
        if (act == ACT_TICK) begin
            if (seq_state != S_RESET_WAIT && seq_state != S_INIT_WAIT &&
                seq_state != S_CONV_WAIT) return 1'b0;
            ticks_left = ticks_left - 8'd1;
            if (ticks_left != '0) return 1'b0;
            case (seq_state)
                S_RESET_WAIT: begin
                    seq_state = S_REINIT;
                    res = request(1'b0, CMD_INIT, CNT_CMD);
                end
                S_INIT_WAIT: begin
                    seq_state = S_STATUS;
                    res = request(1'b1, '0, CNT_STATUS);
                end
                default: begin
                    seq_state = S_DATA;
                    res = request(1'b1, '0, CNT_DATA);
                end
            endcase
            return 1'b1;
        end
        if (act != ACT_DONE) return 1'b0;

        // Completion of the pending bus transfer.
        case (seq_state)
            S_INIT: begin
                if (ok) begin
                    arm_wait(S_INIT_WAIT, cfg_init_wait);
                    return 1'b0;
                end
                seq_state = S_SRESET;
                res = request(1'b0, CMD_SRESET, CNT_SRESET);
                return 1'b1;
            end
            S_SRESET: begin
                arm_wait(S_RESET_WAIT, cfg_reset_wait);
                return 1'b0;
            end
            S_REINIT: begin
                if (!ok) begin
                    res = failure();
                    return 1'b1;
                end
                arm_wait(S_INIT_WAIT, cfg_init_wait);
                return 1'b0;
            end
            S_STATUS: begin
                if (!ok || !rdata[STATUS_CAL_BIT]) begin
                    res = failure();
                    return 1'b1;
                end
                seq_state = S_TRIGGER;
                res = request(1'b0, CMD_TRIGGER, CNT_CMD);
                return 1'b1;
            end
            S_TRIGGER: begin
                if (!ok) begin
                    res = failure();
                    return 1'b1;
                end
                arm_wait(S_CONV_WAIT, cfg_conv_wait);
                return 1'b0;
            end
            S_DATA: begin
                if (!ok || rdata[40 + STATUS_BUSY_BIT]) begin
                    res = failure();
                    return 1'b1;
                end
                // Humidity is bytes 1, 2 and the high nibble of byte 3; temperature the rest.
                h_raw = {12'd0, rdata[39:20]};
                t_raw = {12'd0, rdata[19:0]};
                t_scaled = t_raw * 32'(TEMP_SCALE) + 32'd524288;
                h_scaled = h_raw * 32'(HUM_SCALE) + 32'd524288;
                res.kind = KIND_VALID;
                res.temperature_x10 = t_scaled[31:20] - TEMP_OFFSET;
                res.humidity_pct = (h_scaled[31:20] > 12'(HUM_MAX)) ? HUM_MAX
                                                                    : h_scaled[26:20];
                seq_state = S_IDLE;
                return 1'b1;
            end
            default: return 1'b0;
        endcase
    endfunction

    function automatic string show(input t_result r);
        return $sformatf("kind=%0d rd=%0d addr=%h tx=%h cnt=%0d temp=%0d hum=%0d",
                         r.kind, r.bus_read, r.bus_address, r.tx_bytes, r.byte_count,
                         r.temperature_x10, r.humidity_pct);
    endfunction

    function automatic void report_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS) $display("ERROR at %0t: %s", $time, msg);
    endfunction

    // Writes one register and mirrors it into the predictor; the write enable stays high.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= value;
        @(posedge i_clk);
        case (idx)
            CFG_DEVICE_ADDRESS:     cfg_addr = value[ADDR_W-1:0];
            CFG_RESET_WAIT_MS:      cfg_reset_wait = value;
            CFG_INIT_WAIT_MS:       cfg_init_wait = value;
            CFG_CONVERSION_WAIT_MS: cfg_conv_wait = value;
            default: ;
        endcase
    endtask

    // Drives one input beat in bursts with random gaps, then records what it should cause.
    task automatic send_event(input logic [ACTION_W-1:0] act, input logic ok,
                              input logic [RDATA_W-1:0] rdata, input bit typed,
                              input bit typed_has, input t_result typed_res,
                              output bit effective);
        int gap;
        bit has;
        t_result res;
        seq_state_e was_state;
        logic [WAIT_W-1:0] was_ticks;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap != 0) begin
                in_bus.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(50, 200)
                                                      : $urandom_range(1, 12);
        end
        burst_left--;
        in_bus.valid <= 1'b1;
        in_bus.action <= act;
        in_bus.transfer_ok <= ok;
        in_bus.read_data <= rdata;
        do @(posedge i_clk); while (in_bus.ready !== 1'b1);

        was_state = seq_state;
        was_ticks = ticks_left;
        has = sequence_step(act, ok, rdata, res);
        effective = has || seq_state != was_state || ticks_left != was_ticks;
        if (typed) begin
            has = typed_has;
            res = typed_res;
        end
        if (has) pending_results.push_back(res);
    endtask

    // Picks the next event: mostly what the sensor protocol expects now, some noise.
    task automatic pick_event(input bit tidy, output logic [ACTION_W-1:0] act,
                              output logic ok, output logic [RDATA_W-1:0] rdata);
        logic [63:0] noise;
        noise = {$urandom, $urandom};
        rdata = noise[RDATA_W-1:0];
        ok = 1'b1;
        act = ACT_DONE;
        if (!tidy && $urandom_range(0, 9) == 0) begin
            act = ACTION_W'($urandom_range(0, 3));
            ok = 1'($urandom_range(0, 1));
        end else begin
            case (seq_state)
                S_IDLE:   act = ACT_START;
                S_INIT:   ok = ($urandom_range(0, 3) != 0);
                S_SRESET: ok = 1'($urandom_range(0, 1));
                S_REINIT: ok = ($urandom_range(0, 6) != 0);
                S_STATUS: begin
                    ok = ($urandom_range(0, 9) != 0);
                    rdata[STATUS_CAL_BIT] = ($urandom_range(0, 7) != 0);
                end
                S_TRIGGER: ok = ($urandom_range(0, 9) != 0);
                S_DATA: begin
                    ok = ($urandom_range(0, 9) != 0);
                    rdata[40 + STATUS_BUSY_BIT] = ($urandom_range(0, 6) == 0);
                    // Now and then push both raw values to their extremes.
                    case ($urandom_range(0, 9))
                        0: rdata[39:0] = '0;
                        1: rdata[39:0] = '1;
                        default: ;
                    endcase
                end
                default: act = ACT_TICK;
            endcase
        end
    endtask

    // Stops sending, lets every expected result arrive, then idles.
    task automatic settle();
        in_bus.valid <= 1'b0;
        burst_left = 0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    function automatic logic [WAIT_W-1:0] pick_wait();
        return ($urandom_range(0, 3) != 0) ? WAIT_W'($urandom_range(0, 4))
                                           : WAIT_W'($urandom_range(5, 40));
    endfunction

    // Main stimulus: reset, directed table, then random epochs under changing settings.
    initial begin : stimulus
        int ep;
        int budget;
        int done_items;
        bit eff;
        logic [ACTION_W-1:0] act;
        logic ok;
        logic [RDATA_W-1:0] rdata;
        logic [ADDR_W-1:0] addr;
        logic [WAIT_W-1:0] rw, iw, cw;

        i_rst_n <= 1'b0;
        i_cfg_we <= 1'b0;
        i_cfg_idx <= CFG_DEVICE_ADDRESS;
        i_cfg_data <= '0;
        in_bus.valid <= 1'b0;
        in_bus.action <= ACT_TICK;
        in_bus.transfer_ok <= 1'b0;
        in_bus.read_data <= '0;
        seq_state = S_IDLE;
        ticks_left = '0;
        cfg_addr = DEVICE_ADDRESS_RST;
        cfg_reset_wait = RESET_WAIT_MS_RST;
        cfg_init_wait = INIT_WAIT_MS_RST;
        cfg_conv_wait = CONVERSION_WAIT_MS_RST;
        mismatch_count = 0;
        burst_left = 0;

        dir_rows = '{
            '{ACT_TICK,  1'b1, 48'h0,            1'b1, 1'b0, X_NONE},    // stray tick
            '{ACT_DONE,  1'b1, 48'h0,            1'b1, 1'b0, X_NONE},    // stray completion
            '{ACT_NONE,  1'b1, 48'hFFFFFFFFFFFF, 1'b1, 1'b0, X_NONE},    // unused action
            '{ACT_START, 1'b0, 48'h0,            1'b1, 1'b1, X_INIT},
            '{ACT_START, 1'b1, 48'h0,            1'b1, 1'b0, X_NONE},    // start while busy
            '{ACT_DONE,  1'b0, 48'h0,            1'b1, 1'b1, X_SRESET},  // init fails
            '{ACT_DONE,  1'b0, 48'h0,            1'b0, 1'b0, X_NONE},    // reset outcome ignored
            '{ACT_TICK,  1'b0, 48'h0,            1'b1, 1'b1, X_INIT},    // zero wait is one tick
            '{ACT_DONE,  1'b1, 48'h0,            1'b0, 1'b0, X_NONE},
            '{ACT_TICK,  1'b1, 48'h0,            1'b1, 1'b1, X_STATUS},
            '{ACT_DONE,  1'b1, 48'h08,           1'b1, 1'b1, X_TRIGGER},
            '{ACT_DONE,  1'b1, 48'h0,            1'b0, 1'b0, X_NONE},
            '{ACT_TICK,  1'b1, 48'h0,            1'b1, 1'b1, X_DATA},
            '{ACT_DONE,  1'b1, 48'h7FFFFFFFFFFF, 1'b1, 1'b1, X_HOT},     // full-scale raws
            '{ACT_START, 1'b1, 48'h0,            1'b1, 1'b1, X_INIT},
            '{ACT_DONE,  1'b1, 48'h0,            1'b0, 1'b0, X_NONE},
            '{ACT_TICK,  1'b1, 48'h0,            1'b1, 1'b1, X_STATUS},
            '{ACT_DONE,  1'b1, 48'h08,           1'b0, 1'b0, X_NONE},
            '{ACT_DONE,  1'b1, 48'h0,            1'b0, 1'b0, X_NONE},
            '{ACT_TICK,  1'b1, 48'h0,            1'b1, 1'b1, X_DATA},
            '{ACT_DONE,  1'b1, 48'h800000000000, 1'b1, 1'b1, X_FAIL},    // sensor busy
            '{ACT_START, 1'b1, 48'h0,            1'b1, 1'b1, X_INIT},
            '{ACT_DONE,  1'b1, 48'h0,            1'b0, 1'b0, X_NONE},
            '{ACT_TICK,  1'b1, 48'h0,            1'b1, 1'b1, X_STATUS},
            '{ACT_DONE,  1'b1, 48'hFFFFFFFFFFF7, 1'b1, 1'b1, X_FAIL}     // not calibrated
        };

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Short waits for the directed part; the address keeps its reset value.
        write_reg(CFG_RESET_WAIT_MS, 8'd0);
        write_reg(CFG_INIT_WAIT_MS, 8'd1);
        write_reg(CFG_CONVERSION_WAIT_MS, 8'd1);
        i_cfg_we <= 1'b0;

        foreach (dir_rows[i])
            send_event(dir_rows[i].act, dir_rows[i].ok, dir_rows[i].rdata,
                       dir_rows[i].typed, dir_rows[i].has, dir_rows[i].res, eff);
        settle();

        // Random epochs, each under its own register settings.
        for (ep = 0; ep < NUM_EPOCHS; ep++) begin
            case (ep)
                0: begin
                    addr = ADDR_W'($urandom_range(0, 127));
                    rw = WAIT_W'($urandom_range(0, 3));
                    iw = WAIT_W'($urandom_range(0, 3));
                    cw = WAIT_W'($urandom_range(0, 3));
                    budget = 150;
                end
                1: begin
                    addr = '0;
                    rw = '0;
                    iw = '0;
                    cw = '0;
                    budget = 100;
                end
                2: begin
                    // Full-length waits; the measurement left in flight adds several hundred ticks.
                    addr = '1;
                    rw = '1;
                    iw = '1;
                    cw = '1;
                    budget = 300;
                end
                default: begin
                    addr = ADDR_W'($urandom_range(0, 127));
                    rw = pick_wait();
                    iw = pick_wait();
                    cw = pick_wait();
                    budget = 130;
                end
            endcase
            write_reg(CFG_DEVICE_ADDRESS, {1'b0, addr});
            write_reg(CFG_RESET_WAIT_MS, rw);
            write_reg(CFG_INIT_WAIT_MS, iw);
            write_reg(CFG_CONVERSION_WAIT_MS, cw);
            i_cfg_we <= 1'b0;

            done_items = 0;
            while (done_items < budget) begin
                pick_event(1'b0, act, ok, rdata);
                send_event(act, ok, rdata, 1'b0, 1'b0, X_NONE, eff);
                if (eff) done_items++;
            end
            // Finish the measurement in flight so the registers change only while idle.
            while (seq_state != S_IDLE) begin
                pick_event(1'b1, act, ok, rdata);
                send_event(act, ok, rdata, 1'b0, 1'b0, X_NONE, eff);
            end
            settle();
        end

        if (mismatch_count == 0)
            $display("humidity_sensor_readout_sequencer verification clean");
        else
            $display("humidity_sensor_readout_sequencer verification failed");
        $finish;
    end

    // Receiver: ready runs and stalls of random length, with long stretches of no stall.
    initial begin : rx_pattern
        int hold;
        bit rdy;
        rdy = 1'b0;
        hold = 12;
        out_bus.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold == 0) begin
                rdy = !rdy;
                if (rdy)
                    hold = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 150)
                                                       : $urandom_range(1, 6);
                else
                    hold = $urandom_range(1, 12);
            end else begin
                hold--;
            end
            out_bus.ready <= rdy;
        end
    end

    // Result checker and watchdog on cycles in which no beat moves.
    always @(posedge i_clk) begin
        if (out_bus.valid === 1'b1 && out_bus.ready === 1'b1) begin
            seen = {out_bus.kind, out_bus.bus_read, out_bus.bus_address, out_bus.tx_bytes,
                    out_bus.byte_count, out_bus.temperature_x10, out_bus.humidity_pct};
            if (pending_results.size() == 0) begin
                report_mismatch($sformatf("result beat with none expected: %s", show(seen)));
            end else begin
                want = pending_results.pop_front();
                if (seen !== want)
                    report_mismatch($sformatf("expected %s, got %s", show(want), show(seen)));
            end
        end
        if ((in_bus.valid === 1'b1 && in_bus.ready === 1'b1) ||
            (out_bus.valid === 1'b1 && out_bus.ready === 1'b1)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("humidity_sensor_readout_sequencer verification failed");
                $finish;
            end
        end
    end

endmodule
